### src/fnsf_pkg.sv
// shared constants, types and register codes for the four-neighbour soften filter
package fnsf_pkg;

    // line buffer and frame limits
    localparam int MAX_ROW_PIXELS = 1024;
    localparam int MAX_ROWS       = 4096;
    localparam int COL_W          = $clog2(MAX_ROW_PIXELS);
    localparam int ROW_W          = $clog2(MAX_ROWS);

    // configuration register widths
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 13;
    localparam int CHAN_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // effective width holds both the register range and the buffer depth
    localparam int EW_W = (WIDTH_W > COL_W + 1) ? WIDTH_W : COL_W + 1;

    // pixel layout
    localparam int LANES  = 4;
    localparam int BYTE_W = 8;
    localparam int PIX_W  = LANES * BYTE_W;

    // configuration register index codes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_CHANNELS     = 2'd2
    } t_reg_idx;

    // position of an accepted item within the frame
    typedef struct packed {
        logic             row_ge1;
        logic             avg_en;
        logic             last_row;
        logic             last_col;
        logic             same_col;
        logic [COL_W-1:0] col;
        logic [COL_W-1:0] next_col;
    } t_pos;

    // one result item
    typedef struct packed {
        logic [LANES-1:0][BYTE_W-1:0] chan;
        logic                         last;
    } t_result;

endpackage

### src/four_neighbour_soften_filter_top.sv
// top level of the four-neighbour soften filter
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------
//  cfg     | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//  in      | in        | i_in_valid / o_in_ready   | i_chan0_in .. i_chan3_in
//  out     | out       | o_out_valid / i_out_ready | o_chan0_out .. o_chan3_out,
//          |           |                           | o_frame_last
//
// one item per cycle while the result queue has room; an item is held in the input
// stage, where the line buffer reads issued at acceptance return, then lands in the
// result queue. past the first row, items of the last row give two results, so that
// row is held back by the single result port.
// reset (synchronous, active low) clears counters, queue and registers to
// width 1, height 1, four channels; line buffers are not cleared.
// a result queue without room for the item's results holds the input stage, which then stalls the input.
module four_neighbour_soften_filter_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [fnsf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fnsf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [7:0]                      i_chan0_in,
    input  logic [7:0]                      i_chan1_in,
    input  logic [7:0]                      i_chan2_in,
    input  logic [7:0]                      i_chan3_in,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [7:0]                      o_chan0_out,
    output logic [7:0]                      o_chan1_out,
    output logic [7:0]                      o_chan2_out,
    output logic [7:0]                      o_chan3_out,
    output logic                            o_frame_last
);
    import fnsf_pkg::*;

    t_pos                         pos;
    logic [LANES-1:0]             lane_en;
    logic                         accept;

    logic                         r_s1_valid;
    t_pos                         r_pos;
    logic [PIX_W-1:0]             r_pix;
    logic [PIX_W-1:0]             r_centre;
    logic [PIX_W-1:0]             r_left;

    logic [PIX_W-1:0]             one_rdata;
    logic [PIX_W-1:0]             two_rdata;
    logic [PIX_W-1:0]             avg;
    logic [PIX_W-1:0]             first_pix;
    logic [BYTE_W+1:0]            lane_sum;

    logic [1:0]                   push_need;
    logic [1:0]                   push_n;
    logic [1:0]                   free;
    logic                         s1_fire;
    t_result                      res_a;
    t_result                      res_b;
    t_result                      res_out;

    assign o_cfg_ready = 1'b1;

    // frame position and configuration
    fnsf_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .o_pos       (pos),
        .o_lane_en   (lane_en)
    );

    // input stage handshake
    assign push_need  = {1'b0, r_pos.row_ge1} + {1'b0, r_pos.last_row};
    assign s1_fire    = r_s1_valid && (push_need <= free);
    assign o_in_ready = !r_s1_valid || s1_fire;
    assign accept     = i_in_valid && o_in_ready;
    assign push_n     = s1_fire ? push_need : 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pos <= pos;
            r_pix <= {i_chan3_in, i_chan2_in, i_chan1_in, i_chan0_in};
        end
    end

    // previous row: read ahead at the next column, holds right and next centre
    fnsf_line_ram #(
        .DEPTH (MAX_ROW_PIXELS),
        .WIDTH (PIX_W)
    ) u_row_one (
        .i_clk   (i_clk),
        .i_we    (s1_fire),
        .i_waddr (r_pos.col),
        .i_wdata (r_pix),
        .i_re    (accept),
        .i_raddr (pos.next_col),
        .o_rdata (one_rdata)
    );

    // row before that: gives the upper neighbour
    fnsf_line_ram #(
        .DEPTH (MAX_ROW_PIXELS),
        .WIDTH (PIX_W)
    ) u_row_two (
        .i_clk   (i_clk),
        .i_we    (s1_fire),
        .i_waddr (r_pos.col),
        .i_wdata (r_centre),
        .i_re    (accept),
        .i_raddr (pos.col),
        .o_rdata (two_rdata)
    );

    // centre of the next item and left neighbour carried between items
    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_left   <= r_centre;
            r_centre <= r_pos.same_col ? r_pix : one_rdata;
        end
    end

    // truncated mean of up, down, left and right per lane
    always_comb begin
        lane_sum = '0;
        for (int i = 0; i < LANES; i++) begin
            lane_sum = (BYTE_W+2)'(two_rdata[i*BYTE_W +: BYTE_W]) +
                       (BYTE_W+2)'(r_pix[i*BYTE_W +: BYTE_W]) +
                       (BYTE_W+2)'(r_left[i*BYTE_W +: BYTE_W]) +
                       (BYTE_W+2)'(one_rdata[i*BYTE_W +: BYTE_W]);
            avg[i*BYTE_W +: BYTE_W] = lane_sum[BYTE_W+1:2];
        end
    end

    assign first_pix = r_pos.avg_en ? avg : r_centre;

    // results: pixel one row up, and on the last row the incoming pixel
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            res_a.chan[i] = lane_en[i] ? first_pix[i*BYTE_W +: BYTE_W] : '0;
            res_b.chan[i] = lane_en[i] ? r_pix[i*BYTE_W +: BYTE_W] : '0;
        end
        res_a.last = 1'b0;
        res_b.last = r_pos.last_col;
    end

    // result queue; a lone last-row result goes in the first slot
    fnsf_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (push_n),
        .i_res_a  (r_pos.row_ge1 ? res_a : res_b),
        .i_res_b  (res_b),
        .o_free   (free),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_res    (res_out)
    );

    assign o_chan0_out  = res_out.chan[0];
    assign o_chan1_out  = res_out.chan[1];
    assign o_chan2_out  = res_out.chan[2];
    assign o_chan3_out  = res_out.chan[3];
    assign o_frame_last = res_out.last;

endmodule

### src/fnsf_line_ram.sv
// generic one-write one-read line buffer ram with registered write-first read
module fnsf_line_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, same-cycle write passes through
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            if (i_we && (i_waddr == i_raddr)) begin
                r_rdata <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_raddr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/fnsf_scan.sv
// configuration registers and raster row/column tracking
module fnsf_scan (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [fnsf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fnsf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                          i_accept,
    output fnsf_pkg::t_pos                o_pos,
    output logic [fnsf_pkg::LANES-1:0]    o_lane_en
);
    import fnsf_pkg::*;

    logic [WIDTH_W-1:0]  r_width;
    logic [HEIGHT_W-1:0] r_height;
    logic [CHAN_W-1:0]   r_chan;
    logic [COL_W-1:0]    r_col;
    logic [ROW_W-1:0]    r_row;
    logic [COL_W-1:0]    n_col;
    logic [ROW_W-1:0]    n_row;

    logic [EW_W-1:0]     eff_w;
    logic [HEIGHT_W-1:0] eff_h;
    logic                last_col;
    logic                last_row;

    // configuration writes, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_W'(1);
            r_height <= HEIGHT_W'(1);
            r_chan   <= CHAN_W'(LANES);
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_IMAGE_WIDTH:  r_width  <= i_cfg_data[WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: r_height <= i_cfg_data[HEIGHT_W-1:0];
                REG_CHANNELS:     r_chan   <= i_cfg_data[CHAN_W-1:0];
                default:          r_width  <= r_width;
            endcase
        end
    end

    // effective frame size, zero taken as one and saturated to the limits
    always_comb begin
        eff_w = EW_W'(r_width);
        if (eff_w == '0) begin
            eff_w = EW_W'(1);
        end else if (eff_w > EW_W'(MAX_ROW_PIXELS)) begin
            eff_w = EW_W'(MAX_ROW_PIXELS);
        end
        eff_h = r_height;
        if (eff_h == '0) begin
            eff_h = HEIGHT_W'(1);
        end else if (eff_h > HEIGHT_W'(MAX_ROWS)) begin
            eff_h = HEIGHT_W'(MAX_ROWS);
        end
    end

    // position flags of the item at the input
    assign last_col = (EW_W'(r_col) + EW_W'(1)) >= eff_w;
    assign last_row = (HEIGHT_W'(r_row) + HEIGHT_W'(1)) >= eff_h;

    always_comb begin
        n_col = last_col ? '0 : r_col + COL_W'(1);
        n_row = r_row;
        if (last_col) begin
            n_row = last_row ? '0 : r_row + ROW_W'(1);
        end
    end

    assign o_pos.row_ge1  = (r_row != '0);
    assign o_pos.avg_en   = (r_row > ROW_W'(1)) && (r_col != '0) &&
                            ((EW_W+1)'(r_col) + (EW_W+1)'(2) <= (EW_W+1)'(eff_w));
    assign o_pos.last_row = last_row;
    assign o_pos.last_col = last_col;
    assign o_pos.same_col = (n_col == r_col);
    assign o_pos.col      = r_col;
    assign o_pos.next_col = n_col;

    // counters advance per accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // lanes below the channel count are live
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            o_lane_en[i] = (CHAN_W'(i) < r_chan);
        end
    end

endmodule

### src/fnsf_outq.sv
// two-entry result queue, takes up to two results per cycle and sends one
module fnsf_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [1:0]        i_push_n,
    input  fnsf_pkg::t_result i_res_a,
    input  fnsf_pkg::t_result i_res_b,
    output logic [1:0]        o_free,
    output logic              o_valid,
    input  logic              i_ready,
    output fnsf_pkg::t_result o_res
);
    import fnsf_pkg::*;

    t_result    r_q0;
    t_result    r_q1;
    t_result    n_q0;
    t_result    n_q1;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       pop;
    logic [1:0] after_pop;

    assign pop       = (r_cnt != 2'd0) && i_ready;
    assign after_pop = r_cnt - {1'b0, pop};
    assign o_free    = 2'd2 - after_pop;

    // shift on send, then fill behind what remains
    always_comb begin
        n_q0 = pop ? r_q1 : r_q0;
        n_q1 = r_q1;
        if (i_push_n != 2'd0) begin
            if (after_pop == 2'd0) begin
                n_q0 = i_res_a;
            end else begin
                n_q1 = i_res_a;
            end
        end
        if (i_push_n == 2'd2) begin
            n_q1 = i_res_b;
        end
        n_cnt = after_pop + i_push_n;
    end

    always_ff @(posedge i_clk) begin
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    assign o_valid = (r_cnt != 2'd0);
    assign o_res   = r_q0;

endmodule
